>>> hw/rtl/lmhcd_pkg.sv
// shared types, constants and command codes for the lru min-heap cache directory
// no dependencies; used by lmhcd_ctrl, lmhcd_path and the top level
package lmhcd_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int KEY_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  // read address select
  localparam logic [2:0] RA_ZERO   = 3'd0;
  localparam logic [2:0] RA_PARENT = 3'd1;
  localparam logic [2:0] RA_LEFT   = 3'd2;
  localparam logic [2:0] RA_RIGHT  = 3'd3;
  localparam logic [2:0] RA_SCAN   = 3'd4;
  localparam logic [2:0] RA_LAST   = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [15:0] entry_key;
    logic [31:0] stamp;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        evicted;
    logic [15:0] evicted_key;
    logic [5:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic       ld_req;
    logic       ins_tail;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       scan_start;
    logic       scan_step;
    logic       ev_cap;
    logic       hit_take;
    logic       drop_last;
    logic       ld_last;
    logic       cand_ld;
    logic       put_hold;
    logic       mv_up;
    logic       mv_left;
    logic       mv_right;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic pos_zero;
    logic left_ok;
    logic right_ok;
    logic up_move;
    logic right_take;
    logic cand_less;
    logic scan_hit;
    logic scan_miss;
    logic hit_last;
  } sts_t;

endpackage

>>> hw/rtl/lmhcd_path.sv
// datapath: slot memory, held entry, sift position, entry count, scan pointer, result register
// depends on lmhcd_pkg; driven by lmhcd_ctrl through cmd_t, reports through sts_t
module lmhcd_path #(
  parameter int CAPACITY  = lmhcd_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = lmhcd_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = lmhcd_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lmhcd_pkg::req_t   req,
  input  lmhcd_pkg::cmd_t   cmd,
  output lmhcd_pkg::sts_t   sts,
  output lmhcd_pkg::rsp_t   rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;

  logic [KEY_BITS-1:0]  mem_key  [CAPACITY];
  logic [TIME_BITS-1:0] mem_time [CAPACITY];

  logic [CW-1:0]        count;
  logic [IW-1:0]        pos;
  logic [KEY_BITS-1:0]  hold_key;
  logic [TIME_BITS-1:0] hold_time;
  logic [KEY_BITS-1:0]  cand_key;
  logic [TIME_BITS-1:0] cand_time;
  logic                 cand_less;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_BITS-1:0] rd_time;
  logic [IW-1:0]        rd_addr;
  logic                 rd_scan;
  logic [IW-1:0]        scan_idx;
  logic                 scan_left;
  logic                 res_found;
  logic                 res_evicted;
  logic [KEY_BITS-1:0]  res_ev_key;
  lmhcd_pkg::rsp_t      rsp_q;

  logic [KEY_BITS+15:0]  key_ext;
  logic [TIME_BITS+31:0] time_ext;
  logic [KEY_BITS+15:0]  ev_ext;
  logic [CW+5:0]         occ_ext;
  logic [KEY_BITS-1:0]   req_key;
  logic [TIME_BITS-1:0]  req_time;
  logic [XW-1:0]         left;
  logic [XW-1:0]         right;
  logic [XW-1:0]         count_x;
  logic [IW-1:0]         parent;
  logic [IW-1:0]         last;
  logic [IW-1:0]         raddr;
  logic [TIME_BITS-1:0]  min_time;
  logic                  wr_en;
  logic [KEY_BITS-1:0]   wr_key;
  logic [TIME_BITS-1:0]  wr_time;

  // fields narrower or wider than the port: zero-extend then keep the low bits
  assign key_ext  = {{KEY_BITS{1'b0}}, req.entry_key};
  assign time_ext = {{TIME_BITS{1'b0}}, req.stamp};
  assign req_key  = key_ext[KEY_BITS-1:0];
  assign req_time = time_ext[TIME_BITS-1:0];
  assign ev_ext   = {16'b0, res_ev_key};
  assign occ_ext  = {6'b0, count};

  assign left    = {1'b0, pos, 1'b1};
  assign right   = {1'b0, pos, 1'b0} + XW'(2);
  assign count_x = XW'(count);
  assign parent  = (pos - IW'(1)) >> 1;
  assign last    = IW'(count - CW'(1));

  assign min_time = cand_less ? cand_time : hold_time;

  always_comb begin
    unique case (cmd.rd_sel)
      lmhcd_pkg::RA_ZERO:   raddr = '0;
      lmhcd_pkg::RA_PARENT: raddr = parent;
      lmhcd_pkg::RA_LEFT:   raddr = left[IW-1:0];
      lmhcd_pkg::RA_RIGHT:  raddr = right[IW-1:0];
      lmhcd_pkg::RA_SCAN:   raddr = scan_idx;
      lmhcd_pkg::RA_LAST:   raddr = last;
      default:              raddr = '0;
    endcase
  end

  always_comb begin
    wr_en = cmd.put_hold | cmd.mv_up | cmd.mv_left | cmd.mv_right;
    priority if (cmd.mv_up || cmd.mv_right) begin
      wr_key  = rd_key;
      wr_time = rd_time;
    end else if (cmd.mv_left) begin
      wr_key  = cand_key;
      wr_time = cand_time;
    end else begin
      wr_key  = hold_key;
      wr_time = hold_time;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[pos]  <= wr_key;
      mem_time[pos] <= wr_time;
    end
    if (cmd.rd_en) begin
      rd_key  <= mem_key[raddr];
      rd_time <= mem_time[raddr];
      rd_addr <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_left <= 1'b0;
      rd_scan   <= 1'b0;
    end else begin
      if (cmd.ins_tail) begin
        count <= count + CW'(1);
      end else if (cmd.drop_last) begin
        count <= count - CW'(1);
      end
      rd_scan <= cmd.scan_step & scan_left;
      if (cmd.scan_start) begin
        scan_left <= 1'b1;
      end else if (cmd.scan_step && scan_left) begin
        scan_left <= (scan_idx != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= last;
    end else if (cmd.scan_step && scan_left) begin
      scan_idx <= scan_idx - IW'(1);
    end

    if (cmd.ins_tail) begin
      pos <= IW'(count);
    end else if (cmd.ev_cap) begin
      pos <= '0;
    end else if (cmd.hit_take) begin
      pos <= rd_addr;
    end else if (cmd.mv_up) begin
      pos <= parent;
    end else if (cmd.mv_left) begin
      pos <= left[IW-1:0];
    end else if (cmd.mv_right) begin
      pos <= right[IW-1:0];
    end

    if (cmd.ld_req) begin
      hold_key  <= req_key;
      hold_time <= req_time;
    end else if (cmd.ld_last) begin
      hold_key  <= rd_key;
      hold_time <= rd_time;
    end

    if (cmd.cand_ld) begin
      cand_key  <= rd_key;
      cand_time <= rd_time;
      cand_less <= rd_time < hold_time;
    end

    if (cmd.ld_req) begin
      res_found   <= 1'b0;
      res_evicted <= 1'b0;
      res_ev_key  <= '0;
    end else begin
      if (cmd.ev_cap) begin
        res_evicted <= 1'b1;
        res_ev_key  <= rd_key;
      end
      if (cmd.hit_take) begin
        res_found <= 1'b1;
      end
    end

    if (cmd.out_ld) begin
      rsp_q.found       <= res_found;
      rsp_q.evicted     <= res_evicted;
      rsp_q.evicted_key <= ev_ext[15:0];
      rsp_q.occupancy   <= occ_ext[5:0];
    end
  end

  assign sts.full       = (count == CW'(CAPACITY));
  assign sts.cnt_zero   = (count == '0);
  assign sts.pos_zero   = (pos == '0);
  assign sts.left_ok    = (left < count_x);
  assign sts.right_ok   = (right < count_x);
  assign sts.up_move    = (rd_time > hold_time);
  assign sts.right_take = (right < count_x) && (rd_time < min_time);
  assign sts.cand_less  = cand_less;
  assign sts.scan_hit   = rd_scan && (rd_key == hold_key);
  assign sts.scan_miss  = !scan_left && !rd_scan;
  assign sts.hit_last   = (rd_addr == last);

  assign rsp = rsp_q;

endmodule

>>> hw/rtl/lmhcd_ctrl.sv
// controller: sequences insert, eviction, search and sift steps, owns both handshakes
// depends on lmhcd_pkg; commands lmhcd_path through cmd_t
module lmhcd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_op,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  lmhcd_pkg::sts_t sts,
  output lmhcd_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVICT  = 4'd1;
  localparam logic [3:0] S_UP_RD  = 4'd2;
  localparam logic [3:0] S_UP_CMP = 4'd3;
  localparam logic [3:0] S_DN_L   = 4'd4;
  localparam logic [3:0] S_DN_R   = 4'd5;
  localparam logic [3:0] S_DN_C   = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_TK_LAT = 4'd8;
  localparam logic [3:0] S_TK_DIR = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rsp_valid_next;
  logic       out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    rsp_valid_next = rsp_valid && rsp_stall;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.ld_req = 1'b1;
          if (req_op == lmhcd_pkg::OP_INSERT) begin
            if (sts.full) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = lmhcd_pkg::RA_ZERO;
              state_next = S_EVICT;
            end else begin
              cmd.ins_tail = 1'b1;
              state_next   = S_UP_RD;
            end
          end else if (sts.cnt_zero) begin
            state_next = S_FIN;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_EVICT: begin
        cmd.ev_cap = 1'b1;
        state_next = S_DN_L;
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.put_hold = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = lmhcd_pkg::RA_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_move) begin
          cmd.mv_up  = 1'b1;
          state_next = S_UP_RD;
        end else begin
          cmd.put_hold = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_DN_L: begin
        if (!sts.left_ok) begin
          cmd.put_hold = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = lmhcd_pkg::RA_LEFT;
          state_next = S_DN_R;
        end
      end
      S_DN_R: begin
        cmd.cand_ld = 1'b1;
        if (sts.right_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = lmhcd_pkg::RA_RIGHT;
        end
        state_next = S_DN_C;
      end
      S_DN_C: begin
        // left wins a tie, right only if strictly smaller
        priority if (sts.right_take) begin
          cmd.mv_right = 1'b1;
          state_next   = S_DN_L;
        end else if (sts.cand_less) begin
          cmd.mv_left = 1'b1;
          state_next  = S_DN_L;
        end else begin
          cmd.put_hold = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_SCAN: begin
        priority if (sts.scan_hit) begin
          cmd.hit_take = 1'b1;
          if (sts.hit_last) begin
            cmd.drop_last = 1'b1;
            state_next    = S_FIN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lmhcd_pkg::RA_LAST;
            state_next = S_TK_LAT;
          end
        end else if (sts.scan_miss) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = lmhcd_pkg::RA_SCAN;
        end
      end
      S_TK_LAT: begin
        // last entry fills the hole, then pick a direction
        cmd.ld_last   = 1'b1;
        cmd.drop_last = 1'b1;
        if (sts.pos_zero) begin
          state_next = S_DN_L;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = lmhcd_pkg::RA_PARENT;
          state_next = S_TK_DIR;
        end
      end
      S_TK_DIR: begin
        state_next = sts.up_move ? S_UP_CMP : S_DN_L;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_ld     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> hw/rtl/lru_min_heap_cache_directory_unit.sv
// lru cache directory as a bounded binary min-heap ordered by access time
// insert appends at the tail and climbs toward the root; eviction reads the root, replaces it
// with the new entry and descends; take scans from the newest slot, then the last entry fills
// the hole at the hit slot and sifts up or down (none when the hit is the last slot); a miss scans every slot
// one item in flight, next request can be taken in the same cycle the result appears; single read port
// reset empties the heap at once (count cleared), slot contents are not cleared
module lru_min_heap_cache_directory_unit #(
  parameter int CAPACITY  = lmhcd_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = lmhcd_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = lmhcd_pkg::TIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lmhcd_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lmhcd_pkg::rsp_t rsp
);

  lmhcd_pkg::cmd_t cmd;
  lmhcd_pkg::sts_t sts;

  lmhcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.operation),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lmhcd_path #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_path (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

>>> tb/tb_lru_min_heap_cache_directory_unit.sv
`timescale 1ns / 1ps
// self-checking bench for the lru min-heap cache directory: a directed plan, then random
// insert/take traffic with random idling on both channels, checked against a heap predictor
// depends on lmhcd_pkg and lru_min_heap_cache_directory_unit
module tb_lru_min_heap_cache_directory_unit;

  localparam int DEPTH       = lmhcd_pkg::CAPACITY_DEF;
  localparam int RANDOM_OPS  = 1250;
  localparam int WATCH_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;

  typedef struct {
    lmhcd_pkg::req_t stim;
    logic            typed;
    lmhcd_pkg::rsp_t want;
  } plan_row_t;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_stall;
  lmhcd_pkg::req_t req;
  logic            rsp_valid;
  logic            rsp_stall;
  lmhcd_pkg::rsp_t rsp;

  // predictor copy of the heap
  logic [15:0] slot_k [DEPTH];
  logic [31:0] slot_t [DEPTH];
  int unsigned held;

  lmhcd_pkg::rsp_t due_rsp_q [$];
  plan_row_t       plan [$];
  lmhcd_pkg::rsp_t head;
  int              mismatches = 0;
  int              idle_cycles;
  logic            calm;

  lru_min_heap_cache_directory_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void pair_swap(input int unsigned a, input int unsigned b);
    logic [15:0] k;
    logic [31:0] t;
    k = slot_k[a];
    t = slot_t[a];
    slot_k[a] = slot_k[b];
    slot_t[a] = slot_t[b];
    slot_k[b] = k;
    slot_t[b] = t;
  endfunction

  function automatic void heap_rise(input int unsigned p);
    int unsigned up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (slot_t[up] <= slot_t[p]) break;
      pair_swap(up, p);
      p = up;
    end
  endfunction

  // left child wins a tie, and only a strictly older child moves up
  function automatic void heap_sink(input int unsigned p);
    int unsigned best;
    int unsigned l;
    int unsigned r;
    while (p < held) begin
      best = p;
      l = 2 * p + 1;
      r = 2 * p + 2;
      if (l < held && slot_t[l] < slot_t[best]) best = l;
      if (r < held && slot_t[r] < slot_t[best]) best = r;
      if (best == p) break;
      pair_swap(p, best);
      p = best;
    end
  endfunction

  function automatic lmhcd_pkg::rsp_t heap_apply(input lmhcd_pkg::req_t r);
    lmhcd_pkg::rsp_t res;
    int unsigned     i;
    int unsigned     last;
    logic            hit;
    res = '0;
    if (r.operation == lmhcd_pkg::OP_INSERT) begin
      if (held == DEPTH) begin
        res.evicted = 1'b1;
        res.evicted_key = slot_k[0];
        slot_k[0] = r.entry_key;
        slot_t[0] = r.stamp;
        heap_sink(0);
      end else begin
        slot_k[held] = r.entry_key;
        slot_t[held] = r.stamp;
        held++;
        heap_rise(held - 1);
      end
    end else begin
      // newest slot first, first match wins
      hit = 1'b0;
      i = held;
      while (i > 0 && !hit) begin
        i--;
        if (slot_k[i] == r.entry_key) hit = 1'b1;
      end
      if (hit) begin
        res.found = 1'b1;
        last = held - 1;
        if (i != last) begin
          pair_swap(i, last);
          held = last;
          if (i == 0 || slot_t[i] >= slot_t[(i - 1) / 2]) heap_sink(i);
          else heap_rise(i);
        end else begin
          held = last;
        end
      end
    end
    res.occupancy = 6'(held);
    return res;
  endfunction

  function automatic void plan_add(input logic op, input logic [15:0] key,
                                   input logic [31:0] stamp, input logic typed,
                                   input logic found, input logic evicted,
                                   input logic [5:0] occ);
    plan_row_t row;
    row.stim.operation = op;
    row.stim.entry_key = key;
    row.stim.stamp = stamp;
    row.typed = typed;
    row.want.found = found;
    row.want.evicted = evicted;
    row.want.evicted_key = '0;
    row.want.occupancy = occ;
    plan.push_back(row);
  endfunction

  // entered just after a falling edge, returns at the falling edge after the transfer
  task automatic drive_item(input lmhcd_pkg::req_t stim, input logic typed,
                            input lmhcd_pkg::rsp_t want);
    lmhcd_pkg::rsp_t predicted;
    while (!calm && $urandom_range(99) < 6) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= stim;
    do @(posedge clk); while (req_stall);
    predicted = heap_apply(stim);
    due_rsp_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    rsp_stall <= !calm && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_rsp_q.size() == 0) begin
        $error("result transfer with nothing outstanding: %p", rsp);
        mismatches++;
      end else begin
        head = due_rsp_q.pop_front();
        if (rsp.found !== head.found) begin
          $error("found: expected %0d, got %0d", head.found, rsp.found);
          mismatches++;
        end
        if (rsp.evicted !== head.evicted) begin
          $error("evicted: expected %0d, got %0d", head.evicted, rsp.evicted);
          mismatches++;
        end
        if (rsp.evicted_key !== head.evicted_key) begin
          $error("evicted_key: expected %h, got %h", head.evicted_key, rsp.evicted_key);
          mismatches++;
        end
        if (rsp.occupancy !== head.occupancy) begin
          $error("occupancy: expected %0d, got %0d", head.occupancy, rsp.occupancy);
          mismatches++;
        end
      end
    end
  end

  // ends the run when no transfer happens on either channel for too long
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCH_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("lru_min_heap_cache_directory_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    lmhcd_pkg::req_t item;
    lmhcd_pkg::rsp_t none;
    int unsigned     mode;
    int unsigned     pick;
    logic [31:0]     tick;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    held = 0;
    none = '0;
    tick = 32'd100;
    mode = 0;

    // empty take, extreme keys and stamps, ties, duplicate keys, missing keys,
    // take of root, of the last slot and of interior slots, drain back to empty
    plan_add(lmhcd_pkg::OP_TAKE,   16'h0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd1);
    plan_add(lmhcd_pkg::OP_INSERT, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 6'd2);
    plan_add(lmhcd_pkg::OP_TAKE,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd1);
    plan_add(lmhcd_pkg::OP_TAKE,   16'hFFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 6'd1);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h00AA, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h5555, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'hAAAA, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h00AA, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h0F0F, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'hF0F0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h00AA, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h1234, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'hF0F0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h8000, 32'h4000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h0001, 32'h2000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_INSERT, 16'h7FFF, 32'h1000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h5555, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h00AA, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'hAAAA, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h0F0F, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h8000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h0001, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0);
    plan_add(lmhcd_pkg::OP_TAKE,   16'h7FFF, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 6'd0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[n]) drive_item(plan[n].stim, plan[n].typed, plan[n].want);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm = (n >= 500 && n < 800);
      // fill-heavy, drain-heavy and balanced stretches keep the heap moving between
      // empty and full; the first stretch is fill-heavy so evictions can start early
      if (n % 40 == 0) begin
        pick = $urandom_range(99);
        mode = (n == 0 || pick < 40) ? 0 : (pick < 65) ? 1 : 2;
      end
      pick = $urandom_range(99);
      if (mode == 0)
        item.operation = (pick < 85) ? lmhcd_pkg::OP_INSERT : lmhcd_pkg::OP_TAKE;
      else if (mode == 1)
        item.operation = (pick < 25) ? lmhcd_pkg::OP_INSERT : lmhcd_pkg::OP_TAKE;
      else
        item.operation = (pick < 50) ? lmhcd_pkg::OP_INSERT : lmhcd_pkg::OP_TAKE;

      if (item.operation == lmhcd_pkg::OP_TAKE && held > 0 && $urandom_range(99) < 75)
        item.entry_key = slot_k[$urandom_range(held - 1)];
      else if ($urandom_range(1) == 0)
        item.entry_key = 16'($urandom_range(15));
      else
        item.entry_key = 16'($urandom);

      pick = $urandom_range(99);
      if (pick < 40) begin
        item.stamp = $urandom;
      end else if (pick < 70) begin
        item.stamp = 32'($urandom_range(7));
      end else if (pick < 95) begin
        tick = tick + 32'($urandom_range(3, 1));
        item.stamp = tick;
      end else begin
        item.stamp = ($urandom_range(1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      end

      drive_item(item, 1'b0, none);
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    wait (due_rsp_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("lru_min_heap_cache_directory_unit regression: pass");
    else
      $display("lru_min_heap_cache_directory_unit regression: fail");
    $finish;
  end

endmodule
